>>> design/msem_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msem_pkg: shared types and constants for the multi-unit semaphore
// Field widths, queue sizing, request decoding and the result status codes.
// ----------------------------------------------------------------------------
package msem_pkg;

    // Wait queue sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int TAIL_SUM_W  = PTR_W + 1;

    // Request queue between front and back
    localparam int CMD_DEPTH   = 2;
    localparam int CMD_PTR_W   = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

    // Field widths
    localparam int FUNC_W      = 2;
    localparam int CALLER_W    = 8;
    localparam int UNIT_W      = 16;
    localparam int CNT_W       = 32;
    localparam int THREAD_W    = 8;
    localparam int STATUS_W    = 2;
    localparam int S_DATA_W    = 24;
    localparam int S_USER_W    = 2;
    localparam int M_DATA_W    = 16;
    localparam int M_USER_W    = 1;

    // Request kinds as they arrive on the bus
    localparam logic [FUNC_W-1:0] FUNC_WAIT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SIGNAL = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLOSE  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    // Result kinds
    localparam logic KIND_ANSWER  = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        OP_WAIT,
        OP_SIGNAL,
        OP_CLOSE,
        OP_NONE
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_CLOSED,
        ST_BLOCKED,
        ST_FULL
    } status_t;

    // Classified request handed from front to back
    typedef struct packed {
        op_t                  op;
        logic                 zero;
        logic [CALLER_W-1:0]  caller;
        logic [UNIT_W-1:0]    units;
    } cmd_t;

endpackage : msem_pkg
`default_nettype wire

>>> design/msem_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msem_front: request intake
// Accepts request words, decodes the kind and zero-unit case, and buffers
// the classified requests in a short queue for the execution back end.
// ----------------------------------------------------------------------------
module msem_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // request channel
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [msem_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  wire logic [msem_pkg::S_USER_W-1:0] s_axis_tuser,
    // classified requests to the back end
    output logic                               cmd_valid,
    output msem_pkg::cmd_t                     cmd,
    input  wire logic                          cmd_pop
);

    localparam int CallerW = msem_pkg::CALLER_W;
    localparam int UnitW   = msem_pkg::UNIT_W;
    localparam int CmdPtrW = msem_pkg::CMD_PTR_W;
    localparam int CmdCntW = msem_pkg::CMD_CNT_W;

    msem_pkg::cmd_t           queue_mem [msem_pkg::CMD_DEPTH];
    msem_pkg::cmd_t           in_cmd;
    logic [CmdPtrW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [CmdPtrW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CmdCntW-1:0]       count_reg, count_next;
    logic                     push;
    logic                     pop;

    // Decode the incoming word
    always_comb begin
        in_cmd.caller = s_axis_tdata[CallerW-1:0];
        in_cmd.units  = s_axis_tdata[CallerW +: UnitW];
        in_cmd.zero   = (s_axis_tdata[CallerW +: UnitW] == '0);
        unique case (s_axis_tuser)
            msem_pkg::FUNC_WAIT:   in_cmd.op = msem_pkg::OP_WAIT;
            msem_pkg::FUNC_SIGNAL: in_cmd.op = msem_pkg::OP_SIGNAL;
            msem_pkg::FUNC_CLOSE:  in_cmd.op = msem_pkg::OP_CLOSE;
            msem_pkg::FUNC_NONE:   in_cmd.op = msem_pkg::OP_NONE;
        endcase
    end

    assign s_axis_tready = (count_reg < CmdCntW'(msem_pkg::CMD_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign cmd_valid     = (count_reg != '0);
    assign pop           = cmd_pop && cmd_valid;
    assign cmd           = queue_mem[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == CmdPtrW'(msem_pkg::CMD_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + CmdPtrW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == CmdPtrW'(msem_pkg::CMD_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + CmdPtrW'(1);
        end
        count_next = count_reg + CmdCntW'(push) - CmdCntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the classified word
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule : msem_front
`default_nettype wire

>>> design/msem_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msem_back: semaphore execution
// Holds the unit counter, closed flag and the FIFO of waiting callers,
// executes one request at a time and drives the result register.
// ----------------------------------------------------------------------------
module msem_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_wr_en,
    input  wire logic [msem_pkg::UNIT_W-1:0]   cfg_wr_data,
    // classified requests
    input  wire logic                          cmd_valid,
    input  wire msem_pkg::cmd_t                cmd,
    output logic                               cmd_pop,
    // result channel
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [msem_pkg::M_DATA_W-1:0]      m_axis_tdata,
    output logic [msem_pkg::M_USER_W-1:0]      m_axis_tuser,
    output logic                               m_axis_tlast
);

    localparam int PtrW     = msem_pkg::PTR_W;
    localparam int FillW    = msem_pkg::FILL_W;
    localparam int TailSumW = msem_pkg::TAIL_SUM_W;
    localparam int IdW      = msem_pkg::ID_BITS;
    localparam int UnitW    = msem_pkg::UNIT_W;
    localparam int CntW     = msem_pkg::CNT_W;
    localparam int ThreadW  = msem_pkg::THREAD_W;
    localparam int MDataW   = msem_pkg::M_DATA_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REL,
        S_GAP
    } state_t;

    // Waiter memory
    logic [IdW-1:0]          id_mem   [msem_pkg::QUEUE_DEPTH];
    logic [UnitW-1:0]        need_mem [msem_pkg::QUEUE_DEPTH];
    logic [IdW-1:0]          rd_id0_reg;
    logic [UnitW-1:0]        rd_need0_reg;
    logic [UnitW-1:0]        rd_need1_reg;
    logic                    wr_en;
    logic [PtrW-1:0]         tail;
    logic [TailSumW-1:0]     tail_sum;

    // Control state
    state_t                  state_reg, state_next;
    logic [CntW-1:0]         cnt_reg, cnt_next;
    logic                    closed_reg, closed_next;
    logic [PtrW-1:0]         head_reg, head_next;
    logic [PtrW-1:0]         head_inc;
    logic [FillW-1:0]        fill_reg, fill_next;
    msem_pkg::cmd_t          cmd_reg, cmd_next;
    logic                    rel_close_reg, rel_close_next;

    // Result register
    logic                    out_valid_reg, out_valid_next;
    logic                    out_kind_reg, out_kind_next;
    msem_pkg::status_t       out_status_reg, out_status_next;
    logic [ThreadW-1:0]      out_id_reg, out_id_next;
    logic                    out_last_reg, out_last_next;

    // Datapath
    logic                    out_free;
    logic [CntW:0]           sum_wide;
    logic [CntW-1:0]         sum_sat;
    logic [CntW-1:0]         units_wide;
    logic [CntW-1:0]         after_rel;
    logic                    more;
    logic                    rel;

    assign out_free   = !out_valid_reg || m_axis_tready;
    assign head_inc   = (head_reg == PtrW'(msem_pkg::QUEUE_DEPTH - 1)) ?
                        '0 : head_reg + PtrW'(1);
    assign tail_sum   = TailSumW'(head_reg) + TailSumW'(fill_reg);
    assign tail       = (tail_sum >= TailSumW'(msem_pkg::QUEUE_DEPTH)) ?
                        PtrW'(tail_sum - TailSumW'(msem_pkg::QUEUE_DEPTH)) :
                        PtrW'(tail_sum);
    assign units_wide = CntW'(cmd_reg.units);
    assign sum_wide   = (CntW + 1)'(cnt_reg) + (CntW + 1)'(cmd_reg.units);
    assign sum_sat    = sum_wide[CntW] ? '1 : sum_wide[CntW-1:0];
    assign after_rel  = cnt_reg - CntW'(rd_need0_reg);

    // Next-state logic of the sequencer
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        closed_next     = closed_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        cmd_next        = cmd_reg;
        rel_close_next  = rel_close_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;
        cmd_pop         = 1'b0;
        wr_en           = 1'b0;
        rel             = 1'b0;
        more            = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                // take the next request from the queue
                if (cmd_valid) begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                // execute the request and post its answer
                if (out_free) begin
                    out_status_next = msem_pkg::ST_OK;
                    unique case (cmd_reg.op)
                        msem_pkg::OP_NONE: begin
                        end
                        msem_pkg::OP_WAIT: begin
                            priority if (closed_reg) begin
                                out_status_next = msem_pkg::ST_CLOSED;
                            end else if (cmd_reg.zero) begin
                                out_status_next = msem_pkg::ST_OK;
                            end else if (cnt_reg >= units_wide) begin
                                cnt_next = cnt_reg - units_wide;
                            end else if (fill_reg ==
                                         FillW'(msem_pkg::QUEUE_DEPTH)) begin
                                out_status_next = msem_pkg::ST_FULL;
                            end else begin
                                wr_en           = 1'b1;
                                cnt_next        = '0;
                                fill_next       = fill_reg + FillW'(1);
                                out_status_next = msem_pkg::ST_BLOCKED;
                            end
                        end
                        msem_pkg::OP_SIGNAL: begin
                            if (closed_reg) begin
                                out_status_next = msem_pkg::ST_CLOSED;
                            end else if (!cmd_reg.zero) begin
                                cnt_next = sum_sat;
                                rel      = (fill_reg != '0) &&
                                           (sum_sat >= CntW'(rd_need0_reg));
                            end
                        end
                        msem_pkg::OP_CLOSE: begin
                            if (closed_reg) begin
                                out_status_next = msem_pkg::ST_CLOSED;
                            end else begin
                                closed_next = 1'b1;
                                rel         = (fill_reg != '0);
                                if (fill_reg == '0) begin
                                    head_next = '0;
                                end
                            end
                        end
                    endcase
                    rel_close_next = (cmd_reg.op == msem_pkg::OP_CLOSE);
                    out_valid_next = 1'b1;
                    out_kind_next  = msem_pkg::KIND_ANSWER;
                    out_id_next    = cmd_reg.caller;
                    out_last_next  = !rel;
                    state_next     = rel ? S_REL : S_IDLE;
                end
            end

            S_REL: begin
                // pop the head waiter and post its release
                if (out_free) begin
                    if (rel_close_reg) begin
                        more            = (fill_reg > FillW'(1));
                        head_next       = more ? head_inc : '0;
                        out_status_next = msem_pkg::ST_CLOSED;
                    end else begin
                        more            = (fill_reg > FillW'(1)) &&
                                          (after_rel >= CntW'(rd_need1_reg));
                        cnt_next        = after_rel;
                        head_next       = head_inc;
                        out_status_next = msem_pkg::ST_OK;
                    end
                    fill_next      = fill_reg - FillW'(1);
                    out_valid_next = 1'b1;
                    out_kind_next  = msem_pkg::KIND_RELEASE;
                    out_id_next    = ThreadW'(rd_id0_reg);
                    out_last_next  = !more;
                    state_next     = more ? S_GAP : S_IDLE;
                end
            end

            S_GAP: begin
                // let the head read settle on the new head
                state_next = S_REL;
            end
        endcase

        // load the counter from the register write
        if (cfg_wr_en) begin
            cnt_next = CntW'(cfg_wr_data);
        end
    end

    // Sequencer state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            closed_reg    <= 1'b0;
            head_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            closed_reg     <= closed_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            cmd_reg        <= cmd_next;
            rel_close_reg  <= rel_close_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_status_reg <= out_status_next;
            out_id_reg     <= out_id_next;
            out_last_reg   <= out_last_next;
        end
    end

    // Waiter memory: write at the tail, read the head and the entry after it
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            id_mem[tail]   <= IdW'(cmd_reg.caller);
            need_mem[tail] <= cmd_reg.units - UnitW'(cnt_reg);
        end
        rd_id0_reg   <= id_mem[head_reg];
        rd_need0_reg <= need_mem[head_reg];
        rd_need1_reg <= need_mem[head_inc];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = MDataW'({out_id_reg, out_status_reg});
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule : msem_back
`default_nettype wire

>>> design/multi_unit_semaphore_with_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_unit_semaphore_with_fifo: counting semaphore with a FIFO wait queue
// Takes wait, signal and close requests and returns answers and releases.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel; results leave on m_axis. Each
//   request yields one answer word (tuser 0) followed by one word per
//   released waiter (tuser 1); tlast marks the final word of a request.
//   The counter is loaded by a write on cfg_wr_en / cfg_wr_data, which the
//   user must issue only while no request is in flight; it is not enforced.
// Timing:
//   An idle block passes an accepted request through the request queue,
//   the command register and the result register. The execution sequencer
//   takes each request from the queue, executes it, then posts one release
//   per released waiter, with a gap state between consecutive releases for
//   the registered read of the waiter memory at the new head.
//   A two-word request queue lets the input keep accepting while the
//   sequencer works or the output is stalled.
// Reset:
//   aresetn low clears the counter, closed flag, wait queue and request
//   queue and drops m_axis_tvalid. A stalled receiver holds the result
//   word; the sequencer waits and the request queue fills, then deasserts
//   s_axis_tready.
// ----------------------------------------------------------------------------
module multi_unit_semaphore_with_fifo (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_wr_en,
    input  wire logic [msem_pkg::UNIT_W-1:0]   cfg_wr_data,
    // requests
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] caller_id, [23:8] unit_count
    input  wire logic [msem_pkg::S_DATA_W-1:0] s_axis_tdata,
    // [1:0] func
    input  wire logic [msem_pkg::S_USER_W-1:0] s_axis_tuser,
    // results
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [1:0] status, [9:2] thread_id, [15:10] zero
    output logic [msem_pkg::M_DATA_W-1:0]      m_axis_tdata,
    // [0] kind
    output logic [msem_pkg::M_USER_W-1:0]      m_axis_tuser,
    output logic                               m_axis_tlast
);

    logic            cmd_valid;
    logic            cmd_pop;
    msem_pkg::cmd_t  cmd;

    msem_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    msem_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule : multi_unit_semaphore_with_fifo
`default_nettype wire

>>> design/msem_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msem_checker: port-level checks for the semaphore
// Watches the result channel for stall behavior and legal result words.
// ----------------------------------------------------------------------------
module msem_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [msem_pkg::M_DATA_W-1:0] m_axis_tdata,
    input wire logic [msem_pkg::M_USER_W-1:0] m_axis_tuser,
    input wire logic                          m_axis_tlast
);

    localparam int PadLo = msem_pkg::STATUS_W + msem_pkg::THREAD_W;

    logic [msem_pkg::STATUS_W-1:0] out_status;

    assign out_status = m_axis_tdata[msem_pkg::STATUS_W-1:0];

    // hold a stalled result word
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
        $stable(m_axis_tlast))
    else $error("result word changed while stalled");

    // drop valid out of reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
    else $error("result valid after reset");

    // releases only carry ok or closed
    a_release_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == msem_pkg::KIND_RELEASE) |->
        (out_status == msem_pkg::ST_OK) || (out_status == msem_pkg::ST_CLOSED))
    else $error("release with illegal status");

    // blocked or full answers end their request
    a_blocked_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == msem_pkg::KIND_ANSWER) &&
        ((out_status == msem_pkg::ST_BLOCKED) ||
         (out_status == msem_pkg::ST_FULL)) |-> m_axis_tlast)
    else $error("blocked or full answer followed by releases");

    // keep the pad bits of a result word at zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[msem_pkg::M_DATA_W-1:PadLo] == '0))
    else $error("nonzero pad bits in result word");

endmodule : msem_checker

bind multi_unit_semaphore_with_fifo msem_checker u_msem_checker (.*);
`default_nettype wire
